@@ hw/rtl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  // Default number of list entries held
  localparam int PLE_CAPACITY = 16;

  // Request selector codes
  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } req_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FULL    = 2'd3
  } rsp_status_t;

  // Input item
  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [7:0]         position;
  } req_t;

  // Result item
  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         count;
    logic               entry_valid;
    logic signed [31:0] entry_value;
    logic               last;
  } rsp_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DUMP = 2'd2
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;      // capture the accepted item
    logic exec;       // perform the latched request
    logic dump_step;  // emit one dumped entry
  } ple_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register can take a result
    logic dump_go;    // latched request is a dump of a non-empty list
    logic dump_last;  // current dump index is the final entry
  } ple_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/ple_ctrl.sv @@
// Controller state machine for the positional list engine.
// Depends on ple_pkg for states and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module ple_ctrl
  import ple_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire ple_stat_t stat,
  output ple_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) state_next = stat.dump_go ? ST_DUMP : ST_IDLE;
      end
      ST_DUMP: begin
        if (stat.out_free && stat.dump_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready     = 1'b0;
    cmd.latch     = 1'b0;
    cmd.exec      = 1'b0;
    cmd.dump_step = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      ST_EXEC: begin
        cmd.exec = stat.out_free;
      end
      ST_DUMP: begin
        cmd.dump_step = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ple_dpath.sv @@
// Datapath for the positional list engine: entry store, length, dump index
// and the output register. Depends on ple_pkg; driven by ple_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module ple_dpath
  import ple_pkg::*;
#(
  parameter int CAPACITY = PLE_CAPACITY
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire req_t     req,
  input  wire ple_cmd_t cmd,
  output ple_stat_t     stat,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output rsp_t          rsp
);

  localparam int LenW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  req_t               cur;
  logic [LenW-1:0]    length;
  logic [IdxW-1:0]    dump_idx;
  logic signed [31:0] entries [CAPACITY];

  logic [8:0]      len9;
  logic [8:0]      pos9;
  logic            is_full;
  logic            is_empty;
  logic            do_ins;
  logic            do_del;
  logic [8:0]      slot;
  logic [1:0]      st;
  logic [LenW-1:0] length_next;
  logic            load_exec;

  assign len9     = 9'(length);
  assign pos9     = 9'(cur.position);
  assign is_full  = (len9 >= 9'(CAPACITY));
  assign is_empty = (length == '0);

  // Decode the latched request: status, target slot and kind of update
  always_comb begin
    st     = STAT_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    slot   = '0;
    case (cur.req_type)
      OP_INS_FRONT: begin
        if (is_full) st = STAT_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_BACK: begin
        slot = len9;
        if (is_full) st = STAT_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_AT: begin
        slot = pos9 - 9'd1;
        if (pos9 == 9'd0 || pos9 > len9 + 9'd1) st = STAT_INVALID;
        else if (is_full) st = STAT_FULL;
        else do_ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        if (is_empty) st = STAT_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_BACK: begin
        slot = len9 - 9'd1;
        if (is_empty) st = STAT_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_AT: begin
        slot = pos9 - 9'd1;
        if (pos9 == 9'd0 || pos9 > len9) st = STAT_INVALID;
        else do_del = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    length_next = length;
    if (do_ins) length_next = length + LenW'(1);
    else if (do_del) length_next = length - LenW'(1);
  end

  assign stat.dump_go   = (cur.req_type == OP_DUMP) && !is_empty;
  assign stat.dump_last = (LenW'(dump_idx) + LenW'(1) == length);
  assign stat.out_free  = !rsp_valid || rsp_ready;
  assign load_exec      = cmd.exec && !stat.dump_go;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) cur <= req;
  end

  // Length and dump index
  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      dump_idx <= '0;
    end else begin
      if (cmd.exec) begin
        length   <= length_next;
        dump_idx <= '0;
      end else if (cmd.dump_step) begin
        dump_idx <= dump_idx + IdxW'(1);
      end
    end
  end

  // Shift entries in parallel: open a gap on insert, close it on delete
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (cmd.exec && do_ins) begin
        if (9'(i) == slot) begin
          entries[i] <= cur.value;
        end else if (9'(i) > slot && i > 0) begin
          entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.exec && do_del) begin
        if (9'(i) >= slot && i + 1 < CAPACITY) begin
          entries[i] <= entries[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

  // Output register: hold until taken, load a status or a dumped entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_exec || cmd.dump_step) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_exec) begin
      rsp.status      <= st;
      rsp.count       <= 7'(length_next);
      rsp.entry_valid <= 1'b0;
      rsp.entry_value <= '0;
      rsp.last        <= 1'b1;
    end else if (cmd.dump_step) begin
      rsp.status      <= STAT_OK;
      rsp.count       <= 7'(length);
      rsp.entry_valid <= 1'b1;
      rsp.entry_value <= entries[dump_idx];
      rsp.last        <= stat.dump_last;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/positional_list_engine.sv @@
// Positional list engine: bounded ordered list with insert/delete at a
// position and dump. Top level; depends on ple_pkg, ple_ctrl, ple_dpath.
//
// Usage:
//   Requests enter on req/req_valid/req_ready; results leave on
//   rsp/rsp_valid/rsp_ready. An item moves when valid and ready are high.
//   Each request is an insert (front, back, 1-based position), a delete
//   (front, back, position) or a dump. Every request gives one result with
//   status and the resulting count, except a dump of a non-empty list, which
//   gives one result per entry front to back, last set on the final one.
// Timing:
//   req_ready is high only while the controller is idle. An insert or delete
//   has its result loaded into the output register in the execute state,
//   together with the parallel shift; that state waits while the output
//   register is still full. A dump of a non-empty list first clears the dump
//   index in the execute state, then reads one entry per cycle from the store
//   while the output register can take it. A new request is taken only back
//   in the idle state, once the previous one has loaded its last result.
// Reset and stall:
//   rst (synchronous) empties the list and drops any pending result; the
//   store contents are not cleared. A stalled receiver holds the result in
//   the output register; one further request may be accepted meanwhile and
//   waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int CAPACITY = PLE_CAPACITY
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  ple_cmd_t  cmd;
  ple_stat_t stat;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

@@ bench/tb_positional_list_engine.sv @@
// Self-checking bench for positional_list_engine: a directed table, then random
// grow/shrink/mixed phases, checked against typed results or an in-bench predictor.
// Depends on ple_pkg and the positional_list_engine RTL.
`timescale 1ns / 1ps

module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int LIST_CAP     = PLE_CAPACITY;
  localparam int RANDOM_ITEMS = 230;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = LIST_CAP + 8;

  // Selector value with no operation behind it
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // Directed rows either carry a typed-in result or defer to the predictor
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_t;
  typedef enum int {MV_INSERT, MV_DELETE, MV_DUMP, MV_NOISE} move_t;

  typedef struct {
    req_t item;
    bit   typed;
    rsp_t want;
  } dir_step_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Shadow copy of the list and the results it predicts
  logic signed [31:0] shadow_list [LIST_CAP];
  int   shadow_len    = 0;
  rsp_t pending_rsp[$];

  int errors        = 0;
  int cycle_count   = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int dumps_seen    = 0;
  int peak_len      = 0;
  int status_hits[4] = '{0, 0, 0, 0};
  bit steady_tx     = 1'b0;
  bit steady_rx     = 1'b0;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("positional_list_engine verification failed");
      $finish;
    end
  end

  // Shift later entries up and drop the new value into the gap
  function void open_slot(int idx, logic signed [31:0] val);
    for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[idx] = val;
    shadow_len++;
  endfunction

  // Shift later entries down over the removed one
  function void close_slot(int idx);
    for (int i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
  endfunction

  // Apply one accepted request to the shadow list and queue its results
  function void apply_request(req_t r, bit typed, rsp_t want);
    rsp_t        res;
    rsp_status_t st;
    st  = STAT_OK;
    res = '0;
    case (r.req_type)
      OP_INS_FRONT: begin
        if (shadow_len >= LIST_CAP) st = STAT_FULL;
        else open_slot(0, r.value);
      end
      OP_INS_BACK: begin
        if (shadow_len >= LIST_CAP) st = STAT_FULL;
        else open_slot(shadow_len, r.value);
      end
      OP_INS_AT: begin
        // position range is checked ahead of the full test
        if (r.position < 1 || r.position > shadow_len + 1) st = STAT_INVALID;
        else if (shadow_len >= LIST_CAP) st = STAT_FULL;
        else open_slot(int'(r.position) - 1, r.value);
      end
      OP_DEL_FRONT: begin
        if (shadow_len == 0) st = STAT_EMPTY;
        else close_slot(0);
      end
      OP_DEL_BACK: begin
        if (shadow_len == 0) st = STAT_EMPTY;
        else close_slot(shadow_len - 1);
      end
      OP_DEL_AT: begin
        if (r.position < 1 || r.position > shadow_len) st = STAT_INVALID;
        else close_slot(int'(r.position) - 1);
      end
      OP_DUMP: begin
        // non-empty dump: one result per entry, front to back
        if (shadow_len > 0) begin
          dumps_seen++;
          for (int i = 0; i < shadow_len; i++) begin
            res             = '0;
            res.status      = STAT_OK;
            res.count       = 7'(shadow_len);
            res.entry_valid = 1'b1;
            res.entry_value = shadow_list[i];
            res.last        = (i == shadow_len - 1);
            pending_rsp.push_back(res);
          end
          return;
        end
      end
      default: ;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
    res.status = st;
    res.count  = 7'(shadow_len);
    res.last   = 1'b1;
    pending_rsp.push_back(typed ? want : res);
  endfunction

  function automatic dir_step_t dir_row(logic [2:0] op, logic signed [31:0] val,
                                        logic [7:0] pos, bit typed,
                                        rsp_status_t st, int cnt);
    dir_step_t s;
    s.item.req_type = op;
    s.item.value    = val;
    s.item.position = pos;
    s.typed         = typed;
    s.want          = '0;
    s.want.status   = st;
    s.want.count    = 7'(cnt);
    s.want.last     = 1'b1;
    return s;
  endfunction

  // Mostly legal positions, with edges and raw noise mixed in
  function automatic logic [7:0] pick_position(int top);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70 && top >= 1) return 8'($urandom_range(1, top));
    if (roll < 80) return 8'(top + 1);
    if (roll < 85) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Draw a request shaped by the current phase
  function automatic req_t pick_request(phase_t ph);
    req_op_t ins_ops[3];
    req_op_t del_ops[3];
    req_t    r;
    int      roll;
    move_t   mv;
    ins_ops = '{OP_INS_FRONT, OP_INS_BACK, OP_INS_AT};
    del_ops = '{OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT};
    r.value    = pick_value();
    r.position = 8'($urandom_range(0, 255));
    roll       = $urandom_range(0, 99);
    case (ph)
      PH_GROW:   mv = roll < 80 ? MV_INSERT : roll < 90 ? MV_DUMP : MV_NOISE;
      PH_SHRINK: mv = roll < 75 ? MV_DELETE : roll < 85 ? MV_DUMP : MV_NOISE;
      default: begin
        mv = roll < 35 ? MV_INSERT : roll < 70 ? MV_DELETE : roll < 80 ? MV_DUMP : MV_NOISE;
      end
    endcase
    case (mv)
      MV_INSERT: begin
        r.req_type = ins_ops[$urandom_range(0, 2)];
        if (r.req_type == OP_INS_AT) r.position = pick_position(shadow_len + 1);
      end
      MV_DELETE: begin
        r.req_type = del_ops[$urandom_range(0, 2)];
        if (r.req_type == OP_DEL_AT) r.position = pick_position(shadow_len);
      end
      MV_DUMP:  r.req_type = OP_DUMP;
      default:  r.req_type = 3'($urandom_range(0, 7));
    endcase
    return r;
  endfunction

  // Present one item after a random gap and hold it until accepted
  task automatic send_request(req_t r, bit typed, rsp_t want);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    requests_sent++;
    apply_request(r, typed, want);
  endtask

  function void check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      results_seen++;
      status_hits[rsp.status]++;
      if (pending_rsp.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %p", $time, rsp);
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("count", want.count, rsp.count);
        check_field("entry_valid", want.entry_valid, rsp.entry_valid);
        check_field("entry_value", want.entry_value, rsp.entry_value);
        check_field("last", want.last, rsp.last);
      end
    end
  end

  // Receiver: stall a random number of cycles before taking each item
  initial begin : rsp_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady_rx ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin : stimulus
    dir_step_t steps[$];
    phase_t    ph;
    req_t      r;
    rsp_t      none;
    int        random_count;
    int        phase_len;
    int        phase_idx;

    none = '0;
    // Empty-list cases, bad positions, extremes, then a short build and tear-down
    steps.push_back(dir_row(OP_DEL_FRONT, 32'sd1, 8'd0, TYPED, STAT_EMPTY, 0));
    steps.push_back(dir_row(OP_DEL_BACK, 32'sd2, 8'd0, TYPED, STAT_EMPTY, 0));
    steps.push_back(dir_row(OP_DEL_AT, 32'sd3, 8'd1, TYPED, STAT_INVALID, 0));
    steps.push_back(dir_row(OP_DEL_AT, 32'sd4, 8'd0, TYPED, STAT_INVALID, 0));
    steps.push_back(dir_row(OP_DUMP, 32'sd5, 8'd0, TYPED, STAT_OK, 0));
    steps.push_back(dir_row(OP_INS_AT, 32'sd6, 8'd0, TYPED, STAT_INVALID, 0));
    steps.push_back(dir_row(OP_INS_AT, 32'sd7, 8'd2, TYPED, STAT_INVALID, 0));
    steps.push_back(dir_row(OP_INS_AT, 32'sd5, 8'd1, TYPED, STAT_OK, 1));
    steps.push_back(dir_row(OP_INS_FRONT, 32'sh7FFF_FFFF, 8'hFF, TYPED, STAT_OK, 2));
    steps.push_back(dir_row(OP_INS_BACK, 32'sh8000_0000, 8'hAA, TYPED, STAT_OK, 3));
    steps.push_back(dir_row(OP_INS_AT, -32'sd1, 8'd4, TYPED, STAT_OK, 4));
    steps.push_back(dir_row(OP_INS_AT, 32'sd0, 8'd3, TYPED, STAT_OK, 5));
    steps.push_back(dir_row(OP_INS_AT, 32'sd9, 8'd255, TYPED, STAT_INVALID, 5));
    steps.push_back(dir_row(OP_UNUSED, 32'sh5A5A_A5A5, 8'd9, TYPED, STAT_OK, 5));
    steps.push_back(dir_row(OP_DUMP, 32'sd0, 8'd0, PREDICTED, STAT_OK, 0));
    steps.push_back(dir_row(OP_DEL_AT, 32'sd0, 8'd255, TYPED, STAT_INVALID, 5));
    steps.push_back(dir_row(OP_DEL_AT, 32'sd0, 8'd6, TYPED, STAT_INVALID, 5));
    steps.push_back(dir_row(OP_DEL_AT, 32'sd0, 8'd5, TYPED, STAT_OK, 4));
    steps.push_back(dir_row(OP_DEL_AT, 32'sd0, 8'd2, TYPED, STAT_OK, 3));
    steps.push_back(dir_row(OP_DUMP, 32'sd0, 8'd0, PREDICTED, STAT_OK, 0));
    steps.push_back(dir_row(OP_DEL_FRONT, 32'sd0, 8'd0, TYPED, STAT_OK, 2));
    steps.push_back(dir_row(OP_DEL_BACK, 32'sd0, 8'd0, TYPED, STAT_OK, 1));
    steps.push_back(dir_row(OP_DUMP, 32'sd0, 8'd0, PREDICTED, STAT_OK, 0));
    steps.push_back(dir_row(OP_DEL_AT, 32'sd0, 8'd1, TYPED, STAT_OK, 0));
    steps.push_back(dir_row(OP_DUMP, 32'sd0, 8'd0, TYPED, STAT_OK, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[k]) send_request(steps[k].item, steps[k].typed, steps[k].want);

    // Random phases: fill to capacity, drain past empty, then mix
    random_count = 0;
    phase_idx    = 0;
    while (random_count < RANDOM_ITEMS) begin
      ph        = phase_t'(phase_idx % 3);
      phase_idx++;
      phase_len = $urandom_range(30, 45);
      steady_tx = ($urandom_range(0, 3) == 0);
      steady_rx = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < phase_len && random_count < RANDOM_ITEMS; n++) begin
        r = pick_request(ph);
        send_request(r, PREDICTED, none);
        if (r.req_type != OP_UNUSED) random_count++;
      end
    end
    req_valid <= 1'b0;

    // Drain outstanding results, then allow stray ones to show up
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests, checked %0d results, %0d non-empty dumps, peak depth %0d of %0d.",
             requests_sent, results_seen, dumps_seen, peak_len, LIST_CAP);
    $display("Statuses returned: ok %0d, empty %0d, invalid %0d, full %0d.",
             status_hits[STAT_OK], status_hits[STAT_EMPTY], status_hits[STAT_INVALID],
             status_hits[STAT_FULL]);
    if (errors == 0) begin
      $display("positional_list_engine verification clean");
    end else begin
      $display("positional_list_engine verification failed");
    end
    $finish;
  end

endmodule
